// ----- hdl/lpfp_pkg.sv -----
// Package for the length-prefixed frame parser.
// Holds the event codes, register addresses, configuration and result types.
// No dependencies; imported by lpfp_core and the top level.
`default_nettype none

package lpfp_pkg;

  // ASCII '0', base of the length digit
  localparam logic [7:0] DigitZero = 8'd48;

  // register byte addresses (index * 4)
  localparam logic [3:0] AddrBeginByte   = 4'h0;
  localparam logic [3:0] AddrEndByte     = 4'h4;
  localparam logic [3:0] AddrMaxLength   = 4'h8;
  localparam logic [3:0] AddrHeaderBytes = 4'hC;

  // register reset values
  localparam logic [7:0] RstBeginByte   = 8'd60;
  localparam logic [7:0] RstEndByte     = 8'd62;
  localparam logic [7:0] RstMaxLength   = 8'd10;
  localparam logic [3:0] RstHeaderBytes = 4'd2;

  // event reported for each received byte
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_LENGTH = 3'd1,
    EV_ACTION = 3'd2,
    EV_BODY   = 3'd3,
    EV_DONE   = 3'd4,
    EV_ERROR  = 3'd5
  } event_e;

  typedef struct packed {
    logic [7:0] begin_byte;
    logic [7:0] end_byte;
    logic [7:0] max_length;
    logic [3:0] header_bytes;
  } cfg_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] frame_length;
    logic [7:0] action_code;
    logic [7:0] body_byte;
    logic [7:0] body_position;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/length_prefixed_frame_parser_unit.sv -----
// Length-prefixed frame parser, top level.
// Stream in/out channels, APB-style register port, output result register.
// Depends on lpfp_pkg and lpfp_core.
//
// Usage:
//   s_axis carries one received byte per request (tdata[7:0] = rx_byte).
//   m_axis returns exactly one result per input byte, in order. tuser holds
//   the event code; tdata holds frame_length, action_code, body_byte and
//   body_position from the lowest byte up.
//   Registers: 0x0 begin_byte, 0x4 end_byte, 0x8 max_length, 0xC header_bytes;
//   write them only while no byte is in flight.
// The result is registered and becomes valid in the cycle after input acceptance.
// Throughput is one byte per cycle without a stall: the parser state updates
// in a single combinational step and the result lands in one output register.
// While m_axis is stalled with a result held, s_axis_tready is low; it rises
// again in the cycle the result is taken, so a new byte can enter then.
// Reset returns the parser to hunting for the begin byte, clears the held
// length and action, empties the output register and restores the registers.
`default_nettype none

module length_prefixed_frame_parser_unit
  import lpfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] frame_length, [15:8] action_code,
                                           // [23:16] body_byte, [31:24] body_position
  output logic [2:0]       m_axis_tuser,   // [2:0] event_res
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg_q;
  result_t step_res;
  result_t res_q;
  logic    out_valid_q;
  logic    in_accept;
  logic    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.begin_byte   <= RstBeginByte;
      cfg_q.end_byte     <= RstEndByte;
      cfg_q.max_length   <= RstMaxLength;
      cfg_q.header_bytes <= RstHeaderBytes;
    end else if (cfg_write) begin
      case ({paddr[3:2], 2'b00})
        AddrBeginByte:   cfg_q.begin_byte   <= pwdata[7:0];
        AddrEndByte:     cfg_q.end_byte     <= pwdata[7:0];
        AddrMaxLength:   cfg_q.max_length   <= pwdata[7:0];
        AddrHeaderBytes: cfg_q.header_bytes <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case ({paddr[3:2], 2'b00})
      AddrBeginByte:   prdata = {24'd0, cfg_q.begin_byte};
      AddrEndByte:     prdata = {24'd0, cfg_q.end_byte};
      AddrMaxLength:   prdata = {24'd0, cfg_q.max_length};
      AddrHeaderBytes: prdata = {28'd0, cfg_q.header_bytes};
      default:         prdata = 32'd0;
    endcase
  end

  // accept a byte whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  lpfp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_accept),
    .rx_byte_i (s_axis_tdata),
    .cfg_i     (cfg_q),
    .result_o  (step_res)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.event_res;
  assign m_axis_tdata  = {res_q.body_position, res_q.body_byte,
                          res_q.action_code, res_q.frame_length};

endmodule

`default_nettype wire

// ----- hdl/lpfp_core.sv -----
// Frame parser state machine: phase and held frame registers.
// Updates on each accepted byte and produces that byte's result combinationally.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_core
  import lpfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,     // a byte is accepted this cycle
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output result_t         result_o
);

  typedef enum logic [2:0] {
    PH_BEGIN  = 3'd0,
    PH_LENGTH = 3'd1,
    PH_ACTION = 3'd2,
    PH_BODY   = 3'd3,
    PH_END    = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] length_q, length_d;
  logic [7:0] count_q, count_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] action_q, action_d;

  logic [7:0] digit;
  logic [7:0] header_ext;
  logic       digit_ok;
  logic [7:0] seen_inc;

  // length digit decode and checks
  assign digit      = rx_byte_i - DigitZero;
  assign header_ext = {4'd0, cfg_i.header_bytes};
  assign digit_ok   = (rx_byte_i >= DigitZero) && (digit != 8'd0) &&
                      (digit < cfg_i.max_length) && (digit >= header_ext);
  assign seen_inc   = seen_q + 8'd1;

  // next state and result for the current byte
  always_comb begin
    phase_d  = phase_q;
    length_d = length_q;
    count_d  = count_q;
    seen_d   = seen_q;
    action_d = action_q;
    result_o.event_res     = EV_NONE;
    result_o.body_byte     = 8'd0;
    result_o.body_position = 8'd0;
    case (phase_q)
      PH_LENGTH: begin
        if (digit_ok) begin
          length_d = digit;
          count_d  = digit - header_ext;
          seen_d   = 8'd0;
          phase_d  = PH_ACTION;
          result_o.event_res = EV_LENGTH;
        end else begin
          phase_d  = PH_BEGIN;
          result_o.event_res = EV_ERROR;
        end
      end
      PH_ACTION: begin
        action_d = rx_byte_i;
        phase_d  = (count_q == 8'd0) ? PH_END : PH_BODY;
        result_o.event_res = EV_ACTION;
      end
      PH_BODY: begin
        result_o.body_byte     = rx_byte_i;
        result_o.body_position = seen_q;
        seen_d = seen_inc;
        if (seen_inc >= count_q) begin
          phase_d = PH_END;
        end
        result_o.event_res = EV_BODY;
      end
      PH_END: begin
        result_o.event_res = (rx_byte_i == cfg_i.end_byte) ? EV_DONE : EV_ERROR;
        phase_d = PH_BEGIN;
      end
      default: begin
        // hunting for the begin byte; unused codes land here too
        phase_d = (rx_byte_i == cfg_i.begin_byte) ? PH_LENGTH : PH_BEGIN;
      end
    endcase
    result_o.frame_length = length_d;
    result_o.action_code  = action_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BEGIN;
      length_q <= 8'd0;
      count_q  <= 8'd0;
      seen_q   <= 8'd0;
      action_q <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
      action_q <= action_d;
    end
  end

endmodule

`default_nettype wire
